### design/ggpm_pkg.sv
// ---------------------------------------------------------------------------
// ggpm_pkg
// shared constants, widths and types of the granular grain pool mixer
// ---------------------------------------------------------------------------
package ggpm_pkg;

   localparam int MAX_GRAINS   = 512;
   localparam int SAMPLE_DEPTH = 65536;
   localparam int SAMPLE_BITS  = 16;
   localparam int CAP_SCALE    = 500;

   localparam int SLOT_W  = $clog2(MAX_GRAINS);
   localparam int TOTAL_W = $clog2(MAX_GRAINS + 1);
   localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
   localparam int COUNT_W = $clog2(SAMPLE_DEPTH + 1);

   localparam int FRAC_W   = 17;
   localparam int RATE_W   = 18;
   localparam int STEP_W   = 21;
   localparam int IVAL_W   = 15;
   localparam int CV_W     = 16;
   localparam int MIX_W    = 25;
   localparam int START_W  = FRAC_W + COUNT_W;
   localparam int LEN_W    = FRAC_W + RATE_W;
   localparam int SUM_W    = ((START_W > LEN_W) ? START_W : LEN_W) + 1;
   localparam int IDX_W    = SUM_W - 16;
   localparam int ACC_W    = SAMPLE_BITS + TOTAL_W + 1;
   localparam int PROD_W   = ACC_W + FRAC_W + 1;

   // stream commands
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // register indexes
   localparam logic [3:0] REG_SPAWN_INTERVAL  = 4'd0;
   localparam logic [3:0] REG_START_FRACTION  = 4'd1;
   localparam logic [3:0] REG_LENGTH_FRACTION = 4'd2;
   localparam logic [3:0] REG_HOST_RATE       = 4'd3;
   localparam logic [3:0] REG_STEP_INCREMENT  = 4'd4;
   localparam logic [3:0] REG_CAPACITY_KNOB   = 4'd5;
   localparam logic [3:0] REG_CAPACITY_ATTN   = 4'd6;
   localparam logic [3:0] REG_TRIM_GAIN       = 4'd7;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [LEN_W-1:0]   position;
   } grain_entry_type;

endpackage

### design/ggpm_capacity.sv
// ---------------------------------------------------------------------------
// ggpm_capacity
// two-stage capacity pipeline: cv * attn * 500 plus knob * 500 * 2^15,
// floored by 2^31 and saturated to 0..MAX_GRAINS
// ---------------------------------------------------------------------------
module ggpm_capacity (
   input  logic                          clock,
   input  logic signed [ggpm_pkg::CV_W-1:0]   capacity_cv,
   input  logic [ggpm_pkg::FRAC_W-1:0]   capacity_attn,
   input  logic [ggpm_pkg::FRAC_W-1:0]   capacity_knob,
   output logic [ggpm_pkg::TOTAL_W-1:0]  capacity
);
   import ggpm_pkg::*;

   localparam int P1_W = CV_W + FRAC_W + 1;
   localparam int K_W  = FRAC_W + 10;
   localparam int S_W  = P1_W + 10 + 2;

   logic signed [P1_W-1:0] cv_prod_ff;
   logic [K_W-1:0]         knob_prod_ff;
   logic signed [S_W-1:0]  s_ff;
   logic signed [S_W-1:0]  s_in;
   logic signed [S_W-32:0] s_shift;

   always_comb begin
      s_in = S_W'(cv_prod_ff) * S_W'(signed'(CAP_SCALE))
           + (S_W'(signed'({1'b0, knob_prod_ff})) <<< 15);
      s_shift = s_ff[S_W-1:31];
   end

   always_ff @(posedge clock) begin
      cv_prod_ff   <= P1_W'(capacity_cv) * P1_W'(signed'({1'b0, capacity_attn}));
      knob_prod_ff <= K_W'(capacity_knob) * K_W'(CAP_SCALE);
      s_ff         <= s_in;
   end

   // negative sums give zero, large ones saturate
   always_comb begin
      if (s_ff < 0) begin
         capacity = '0;
      end else if (s_shift > (S_W-31)'(MAX_GRAINS)) begin
         capacity = TOTAL_W'(MAX_GRAINS);
      end else begin
         capacity = TOTAL_W'(s_shift);
      end
   end

endmodule

### design/granular_grain_pool_mixer.sv
// ---------------------------------------------------------------------------
// granular_grain_pool_mixer
// granular player over a sample memory with a ring of grain slots
// ---------------------------------------------------------------------------
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser command, tdata sample/cv
// rsp     | out | rsp_tvalid/tready    | tdata mix, spawned, active grains
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// append, clear and unknown commands go straight to the result; a tick
// runs the product, spawn and trim steps, a walk over the live grains (one
// grain memory entry and one sample word read per cycle), drain, scale and
// saturate; an empty store or no grains left ends it after the trim step.
// reset is synchronous and clears counters, ring pointers and the held
// output; the memories are not cleared. an input transfer is taken while
// a result still waits; the next result waits until the output is free.
// ---------------------------------------------------------------------------
module granular_grain_pool_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_word, [31:16] capacity_cv
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [24:0] mix_out, [25] spawned,
                                    // [35:26] active_grains, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [20:0] csr_data
);
   import ggpm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_SPAWN, S_TRIM, S_WALK, S_DRAIN, S_SCALE, S_SAT, S_DONE
   } state_type;

   // configuration registers
   logic [IVAL_W-1:0] spawn_interval_ff;
   logic [FRAC_W-1:0] start_fraction_ff, length_fraction_ff;
   logic [RATE_W-1:0] host_rate_ff;
   logic [STEP_W-1:0] step_increment_ff;
   logic [FRAC_W-1:0] capacity_knob_ff, capacity_attn_ff, trim_gain_ff;

   // control state
   state_type          state_ff;
   logic [COUNT_W-1:0] sample_count_ff;
   logic [SLOT_W-1:0]  oldest_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [IVAL_W-1:0]  counter_ff;
   logic signed [MIX_W-1:0] held_ff;
   logic               spawn_ff;
   logic               rsp_valid_ff;
   logic [39:0]        rsp_data_ff;

   // captured item and products
   logic signed [CV_W-1:0]  cv_ff;
   logic [START_W-1:0]      start_prod_ff;
   logic [LEN_W-1:0]        len_prod_ff;

   // walk pipeline
   logic [SLOT_W-1:0]  walk_slot_ff;
   logic [TOTAL_W-1:0] walk_left_ff;
   logic               v1_ff, v2_ff, inr2_ff;
   logic [SLOT_W-1:0]  slot1_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // memories
   logic [SAMPLE_BITS-1:0] sample_mem [SAMPLE_DEPTH];
   logic [SAMPLE_BITS-1:0] sample_rd_ff;
   grain_entry_type        grain_mem [MAX_GRAINS];
   grain_entry_type        grain_rd_ff;

   logic [TOTAL_W-1:0] capacity;
   logic               accept;
   logic               out_free;

   ggpm_capacity u_capacity (
      .clock         (clock),
      .capacity_cv   (cv_ff),
      .capacity_attn (capacity_attn_ff),
      .capacity_knob (capacity_knob_ff),
      .capacity      (capacity)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spawn_interval_ff   <= IVAL_W'(6000);
         start_fraction_ff   <= '0;
         length_fraction_ff  <= FRAC_W'(32768);
         host_rate_ff        <= RATE_W'(48000);
         step_increment_ff   <= STEP_W'(65536);
         capacity_knob_ff    <= FRAC_W'(65536);
         capacity_attn_ff    <= '0;
         trim_gain_ff        <= FRAC_W'(65536);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SPAWN_INTERVAL:  spawn_interval_ff  <= csr_data[IVAL_W-1:0];
            REG_START_FRACTION:  start_fraction_ff  <= csr_data[FRAC_W-1:0];
            REG_LENGTH_FRACTION: length_fraction_ff <= csr_data[FRAC_W-1:0];
            REG_HOST_RATE:       host_rate_ff       <= csr_data[RATE_W-1:0];
            REG_STEP_INCREMENT:  step_increment_ff  <= csr_data[STEP_W-1:0];
            REG_CAPACITY_KNOB:   capacity_knob_ff   <= csr_data[FRAC_W-1:0];
            REG_CAPACITY_ATTN:   capacity_attn_ff   <= csr_data[FRAC_W-1:0];
            REG_TRIM_GAIN:       trim_gain_ff       <= csr_data[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- combinational helpers ----
   // spawn: drop oldest when full, then the new slot sits after the ring
   logic [SLOT_W-1:0]  sp_oldest;
   logic [TOTAL_W-1:0] sp_total;
   logic [SLOT_W:0]    sp_slot_sum;
   logic [SLOT_W-1:0]  sp_slot;
   // capacity trim
   logic [SLOT_W:0]    tr_sum;
   logic [SLOT_W-1:0]  tr_oldest;
   logic [TOTAL_W-1:0] tr_total;

   always_comb begin
      if (total_ff >= TOTAL_W'(MAX_GRAINS)) begin
         sp_oldest = (oldest_ff == SLOT_W'(MAX_GRAINS - 1)) ? '0 : oldest_ff + 1'b1;
         sp_total  = total_ff - 1'b1;
      end else begin
         sp_oldest = oldest_ff;
         sp_total  = total_ff;
      end
      sp_slot_sum = {1'b0, sp_oldest} + (SLOT_W+1)'(sp_total);
      sp_slot = (sp_slot_sum >= (SLOT_W+1)'(MAX_GRAINS))
              ? SLOT_W'(sp_slot_sum - (SLOT_W+1)'(MAX_GRAINS)) : SLOT_W'(sp_slot_sum);

      if (total_ff > capacity) begin
         tr_sum   = {1'b0, oldest_ff} + (SLOT_W+1)'(total_ff - capacity);
         tr_total = capacity;
      end else begin
         tr_sum   = {1'b0, oldest_ff};
         tr_total = total_ff;
      end
      tr_oldest = (tr_sum >= (SLOT_W+1)'(MAX_GRAINS))
                ? SLOT_W'(tr_sum - (SLOT_W+1)'(MAX_GRAINS)) : SLOT_W'(tr_sum);
   end

   // stage one of the walk: sample index and advanced position
   logic [SUM_W-1:0]   idx_sum;
   logic [IDX_W-1:0]   idx;
   logic               idx_in;
   logic [LEN_W:0]     pos_add;
   logic [LEN_W:0]     pos_sub;
   logic [LEN_W-1:0]   pos_in;
   grain_entry_type    grain_wr;

   always_comb begin
      idx_sum = SUM_W'(grain_rd_ff.start) + SUM_W'(grain_rd_ff.position);
      idx     = idx_sum[SUM_W-1:16];
      idx_in  = idx < IDX_W'(sample_count_ff);
      pos_add = (LEN_W+1)'(grain_rd_ff.position) + (LEN_W+1)'(step_increment_ff);
      pos_sub = (pos_add >= (LEN_W+1)'(grain_rd_ff.length))
              ? pos_add - (LEN_W+1)'(grain_rd_ff.length) : pos_add;
      pos_in  = (pos_sub >= (LEN_W+1)'(grain_rd_ff.length)) ? '0 : LEN_W'(pos_sub);
      grain_wr          = grain_rd_ff;
      grain_wr.position = pos_in;
   end

   // trimmed mix, floor by 2^16 then saturate
   logic signed [PROD_W-17:0] mix_q;
   logic signed [MIX_W-1:0]   mix_sat;
   always_comb begin
      mix_q = prod_ff[PROD_W-1:16];
      if (mix_q > (PROD_W-16)'(signed'(MIX_W'({1'b0, {(MIX_W-1){1'b1}}})))) begin
         mix_sat = {1'b0, {(MIX_W-1){1'b1}}};
      end else if (mix_q < (PROD_W-16)'(signed'({1'b1, {(MIX_W-1){1'b0}}}))) begin
         mix_sat = {1'b1, {(MIX_W-1){1'b0}}};
      end else begin
         mix_sat = MIX_W'(mix_q);
      end
   end

   // sample memory: append write, walk read
   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_APPEND &&
          sample_count_ff < COUNT_W'(SAMPLE_DEPTH)) begin
         sample_mem[sample_count_ff[ADDR_W-1:0]] <= req_tdata[SAMPLE_BITS-1:0];
      end
      sample_rd_ff <= sample_mem[idx[ADDR_W-1:0]];
   end

   // grain memory: spawn write or walk write-back, walk read
   always_ff @(posedge clock) begin
      if (state_ff == S_SPAWN && spawn_ff) begin
         grain_mem[sp_slot] <= '{start: start_prod_ff, length: len_prod_ff,
                                 position: '0};
      end else if (v1_ff) begin
         grain_mem[slot1_ff] <= grain_wr;
      end
      grain_rd_ff <= grain_mem[walk_slot_ff];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cv_ff  <= req_tdata[31:16];
      end
      start_prod_ff <= START_W'(start_fraction_ff) * START_W'(sample_count_ff);
      len_prod_ff   <= LEN_W'(length_fraction_ff) * LEN_W'(host_rate_ff);
      slot1_ff      <= walk_slot_ff;
      inr2_ff       <= idx_in;
      prod_ff       <= PROD_W'(acc_ff) * PROD_W'(signed'({1'b0, trim_gain_ff}));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sample_count_ff <= '0;
         oldest_ff       <= '0;
         total_ff        <= '0;
         counter_ff      <= '0;
         held_ff         <= '0;
         spawn_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         walk_left_ff    <= '0;
         walk_slot_ff    <= '0;
         acc_ff          <= '0;
      end else begin
         // a new result is loaded only from S_DONE, so clear elsewhere
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         // walk pipeline stages
         v1_ff <= (state_ff == S_WALK) && (walk_left_ff != '0);
         v2_ff <= v1_ff;
         if (v2_ff && inr2_ff) begin
            acc_ff <= acc_ff + ACC_W'(signed'(sample_rd_ff));
         end

         unique case (state_ff)
            S_IDLE: begin
               spawn_ff <= 1'b0;
               if (accept) begin
                  priority case (req_tuser)
                     CMD_APPEND: begin
                        if (sample_count_ff < COUNT_W'(SAMPLE_DEPTH))
                           sample_count_ff <= sample_count_ff + 1'b1;
                        state_ff <= S_DONE;
                     end
                     CMD_CLEAR: begin
                        sample_count_ff <= '0;
                        state_ff <= S_DONE;
                     end
                     CMD_TICK: state_ff <= S_PROD;
                     default:  state_ff <= S_DONE;
                  endcase
               end
            end
            S_PROD: begin
               spawn_ff <= (counter_ff >= spawn_interval_ff);
               state_ff <= S_SPAWN;
            end
            S_SPAWN: begin
               if (spawn_ff) begin
                  oldest_ff  <= sp_oldest;
                  total_ff   <= sp_total + 1'b1;
                  counter_ff <= '0;
               end
               state_ff <= S_TRIM;
            end
            S_TRIM: begin
               oldest_ff    <= tr_oldest;
               total_ff     <= tr_total;
               walk_slot_ff <= tr_oldest;
               walk_left_ff <= tr_total;
               acc_ff       <= '0;
               if (sample_count_ff == '0) begin
                  held_ff  <= '0;
                  state_ff <= S_DONE;
               end else begin
                  counter_ff <= counter_ff + 1'b1;
                  state_ff   <= (tr_total == '0) ? S_DONE : S_WALK;
               end
            end
            S_WALK: begin
               if (walk_left_ff != '0) begin
                  walk_left_ff <= walk_left_ff - 1'b1;
                  walk_slot_ff <= (walk_slot_ff == SLOT_W'(MAX_GRAINS - 1))
                                ? '0 : walk_slot_ff + 1'b1;
               end else begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!v1_ff && !v2_ff) state_ff <= S_SCALE;
            end
            S_SCALE: state_ff <= S_SAT;
            S_SAT: begin
               held_ff  <= mix_sat;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'd0, total_ff, spawn_ff, held_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---- assertions ----
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_W'(MAX_GRAINS))
      else $error("grain count above ring size");

   a_walk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!v1_ff && !v2_ff))
      else $error("walk pipeline busy while idle");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("sample stage without grain stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting result changed or dropped");

endmodule
